// File: rtl/core/yee_fdtd_1d_field_advance_macros.svh
// Assertion macros shared by the field advance RTL.
`ifndef YEE_FDTD_1D_FIELD_ADVANCE_MACROS_SVH
`define YEE_FDTD_1D_FIELD_ADVANCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define YFA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define YFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/yfa_pkg.sv
// Types, codes and arithmetic helpers for the 1D field advance block.
`default_nettype none

package yfa_pkg;

   // Opcodes
   localparam logic [2:0] OP_WRITE_E = 3'd0;
   localparam logic [2:0] OP_WRITE_B = 3'd1;
   localparam logic [2:0] OP_WRITE_J = 3'd2;
   localparam logic [2:0] OP_ADVANCE = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_SIZE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_COURANT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COURANT       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MUR_COEFF     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOUNDARY_MODE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_ENABLE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_COUNT    = 3'd7;

   // Arithmetic widths
   localparam int unsigned FRAC_W = 24;
   localparam int unsigned OPND_W = 33;
   localparam int unsigned PROD_W = 2 * OPND_W;
   localparam int unsigned TERM_W = PROD_W - FRAC_W;
   localparam int unsigned ACC_W  = 48;
   localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(8388608);

   typedef struct packed {
      logic [2:0]         opcode;
      logic [10:0]        cell_slot;
      logic signed [31:0] comp_x;
      logic signed [31:0] comp_y;
      logic signed [31:0] comp_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] e_x;
      logic signed [31:0] e_y;
      logic signed [31:0] e_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic               window_moved;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec3_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               clip;
   } sat_type;

   // Clip a wide sum to 32 bits
   function automatic sat_type sat32(input logic signed [ACC_W-1:0] v);
      sat_type r;
      if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
         r.val  = v[31:0];
         r.clip = 1'b0;
      end else begin
         r.val  = v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         r.clip = 1'b1;
      end
      return r;
   endfunction

   // Product rounded to 24 fraction bits (Q18.24): add one half, floor
   function automatic logic signed [TERM_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      r = p + signed'(HALF_LSB);
      return r[PROD_W-1:FRAC_W];
   endfunction

   function automatic logic signed [ACC_W-1:0] ext32(input logic signed [31:0] v);
      return {{(ACC_W-32){v[31]}}, v};
   endfunction

   function automatic logic signed [ACC_W-1:0] ext_term(input logic signed [TERM_W-1:0] t);
      return {{(ACC_W-TERM_W){t[TERM_W-1]}}, t};
   endfunction

   function automatic logic signed [OPND_W-1:0] diff33(input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
      return {a[31], a} - {b[31], b};
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/yee_fdtd_1d_field_advance.sv
// 1D leapfrog E/B field solver with cell memories, boundaries and moving window.
//
// Each of E, B and J lives in one single-port-per-side memory of MAX_CELLS+3
// three-component words; slot k holds grid cell k-1. After reset the block
// runs a clearing pass over every slot during which no transaction is
// taken (configuration writes still are). An advance walks the memories
// slot by slot through one shared 33x33 multiplier in half B passes, the E
// pass, open boundaries or periodic guards, the window test and a window
// shift; its length is set by the one read port per memory and the single
// multiplier. Results leave through an output register, so a transaction is
// taken while the previous result still waits.
`default_nettype none

`include "yee_fdtd_1d_field_advance_macros.svh"

module yee_fdtd_1d_field_advance
   import yfa_pkg::*;
#(
   parameter int MAX_CELLS = 1024
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output rsp_type               rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_data
);

   localparam int SLOTS  = MAX_CELLS + 3;
   localparam int SLOT_W = $clog2(SLOTS);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_READ  = 4'd2;
   localparam logic [3:0] ST_PUT   = 4'd3;
   localparam logic [3:0] ST_HB    = 4'd4;
   localparam logic [3:0] ST_E     = 4'd5;
   localparam logic [3:0] ST_MUR   = 4'd6;
   localparam logic [3:0] ST_GUARD = 4'd7;
   localparam logic [3:0] ST_STEP  = 4'd8;
   localparam logic [3:0] ST_WIN   = 4'd9;
   localparam logic [3:0] ST_SHIFT = 4'd10;
   localparam logic [3:0] ST_ZERO  = 4'd11;

   // Control
   logic [3:0]        state_ff;
   logic [3:0]        sub_ff;
   logic [SLOT_W-1:0] s_ff;
   logic [SLOT_W-1:0] nx_ff;
   logic              pass2_ff;
   logic              side_ff;
   logic              clip_ff;
   logic              rd_ok_ff;

   // Configuration
   logic [30:0]        dt_ff;
   logic [30:0]        cs_ff;
   logic [30:0]        hc_ff;
   logic [30:0]        cr_ff;
   logic signed [25:0] mur_k_ff;
   logic               bmode_ff;
   logic               wen_ff;
   logic [10:0]        cc_ff;

   // Step state
   logic [31:0]       step_ff;
   logic [31:0]       wsc_ff;
   logic [1:0][31:0]  mur_bf_lo_ff;
   logic [1:0][31:0]  mur_bf_hi_ff;
   logic [1:0][31:0]  mur_pe_lo_ff;
   logic [1:0][31:0]  mur_pe_hi_ff;

   // Datapath
   vec3_type                 e_cur_ff, e_nxt_ff, b_cur_ff, b_prv_ff, j_cur_ff;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_y_ff, acc_z_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [63:0]              trav_ff;
   rsp_type                  res_ff;
   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff;

   // Memories
   vec3_type e_mem [SLOTS];
   vec3_type b_mem [SLOTS];
   vec3_type j_mem [SLOTS];
   vec3_type e_rd_ff, b_rd_ff;
   vec3_type j_rd_ff;

   logic [SLOT_W-1:0] e_raddr, b_raddr, j_raddr;
   logic              e_we, b_we, j_we;
   logic [SLOT_W-1:0] e_waddr, b_waddr, j_waddr;
   vec3_type          e_wdata, b_wdata, j_wdata;

   logic signed [OPND_W-1:0] mul_a, mul_b;
   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  z_sum;
   sat_type                  sat_x, sat_y, sat_z;
   logic                     wr_clip;

   logic [31:0]       slot32;
   logic              slot_ok;
   logic [SLOT_W-1:0] req_addr;
   logic              req_take;
   logic [31:0]       cc32;
   logic [31:0]       nx_calc;
   logic [SLOT_W-1:0] mur_inner, mur_edge;
   logic [1:0][31:0]  bf_sel, pe_sel;
   logic [64:0]       win_limit;
   logic              last_slot;

   // Handshakes
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // Request slot decode and cell count clamp
   assign slot32   = 32'(req_data.cell_slot);
   assign slot_ok  = (slot32 < 32'(SLOTS));
   assign req_addr = slot32[SLOT_W-1:0];
   assign cc32     = 32'(cc_ff);
   assign nx_calc  = (cc32 < 32'd2) ? 32'd2 :
                     (cc32 > 32'(MAX_CELLS)) ? 32'(MAX_CELLS) : cc32;

   // Boundary side selection
   assign mur_inner = side_ff ? nx_ff : SLOT_W'(1);
   assign mur_edge  = side_ff ? (nx_ff + SLOT_W'(1)) : '0;
   assign bf_sel    = side_ff ? mur_bf_hi_ff : mur_bf_lo_ff;
   assign pe_sel    = side_ff ? mur_pe_hi_ff : mur_pe_lo_ff;

   // Rounded product of the previous cycle
   assign term = round_q(prod_ff);

   // Saturation of the values written back
   always_comb begin
      unique case (state_ff)
         ST_HB:   z_sum = ext32(b_cur_ff.z) - ext_term(term);
         ST_E:    z_sum = acc_z_ff - ext_term(term);
         ST_MUR:  z_sum = ext32(pe_sel[1]) + ext_term(term);
         default: z_sum = '0;
      endcase
   end
   assign sat_x = sat32(acc_x_ff);
   assign sat_y = sat32(acc_y_ff);
   assign sat_z = sat32(z_sum);

   assign win_limit = {1'b0, prod_ff[63:0]} + 65'(cs_ff);

   // Memory port control and multiplier operands
   always_comb begin
      e_raddr = s_ff;
      b_raddr = s_ff;
      j_raddr = s_ff;
      e_we    = 1'b0;
      b_we    = 1'b0;
      j_we    = 1'b0;
      e_waddr = s_ff;
      b_waddr = s_ff;
      j_waddr = s_ff;
      e_wdata = '0;
      b_wdata = '0;
      j_wdata = '0;
      mul_a   = '0;
      mul_b   = '0;
      wr_clip = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            e_we = 1'b1;
            b_we = 1'b1;
            j_we = 1'b1;
         end
         ST_IDLE: begin
            e_raddr = req_addr;
            b_raddr = req_addr;
            e_waddr = req_addr;
            b_waddr = req_addr;
            j_waddr = req_addr;
            e_wdata = {req_data.comp_x, req_data.comp_y, req_data.comp_z};
            b_wdata = {req_data.comp_x, req_data.comp_y, req_data.comp_z};
            j_wdata = {req_data.comp_x, req_data.comp_y, req_data.comp_z};
            e_we    = req_take && slot_ok && (req_data.opcode == OP_WRITE_E);
            b_we    = req_take && slot_ok && (req_data.opcode == OP_WRITE_B);
            j_we    = req_take && slot_ok && (req_data.opcode == OP_WRITE_J);
         end
         ST_HB: begin
            if (sub_ff == 4'd1) begin
               e_raddr = s_ff + SLOT_W'(1);
            end
            if (sub_ff == 4'd3) begin
               mul_a = {2'b00, hc_ff};
               mul_b = diff33(e_nxt_ff.z, e_cur_ff.z);
            end
            if (sub_ff == 4'd4) begin
               mul_a = {2'b00, hc_ff};
               mul_b = diff33(e_nxt_ff.y, e_cur_ff.y);
            end
            if (sub_ff == 4'd5) begin
               b_we    = 1'b1;
               b_wdata = {b_cur_ff.x, sat_y.val, sat_z.val};
               wr_clip = sat_y.clip | sat_z.clip;
            end
         end
         ST_E: begin
            if (sub_ff == 4'd0) begin
               b_raddr = s_ff - SLOT_W'(1);
            end
            unique case (sub_ff)
               4'd3: begin
                  mul_a = {2'b00, dt_ff};
                  mul_b = {j_cur_ff.x[31], j_cur_ff.x};
               end
               4'd4: begin
                  mul_a = {2'b00, cr_ff};
                  mul_b = diff33(b_cur_ff.z, b_prv_ff.z);
               end
               4'd5: begin
                  mul_a = {2'b00, dt_ff};
                  mul_b = {j_cur_ff.y[31], j_cur_ff.y};
               end
               4'd6: begin
                  mul_a = {2'b00, cr_ff};
                  mul_b = diff33(b_cur_ff.y, b_prv_ff.y);
               end
               4'd7: begin
                  mul_a = {2'b00, dt_ff};
                  mul_b = {j_cur_ff.z[31], j_cur_ff.z};
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
            if (sub_ff == 4'd8) begin
               e_we    = 1'b1;
               e_wdata = {sat_x.val, sat_y.val, sat_z.val};
               wr_clip = sat_x.clip | sat_y.clip | sat_z.clip;
            end
         end
         ST_MUR: begin
            e_raddr = (sub_ff == 4'd0) ? mur_inner : mur_edge;
            e_waddr = mur_edge;
            if (sub_ff == 4'd2) begin
               mul_a = {{7{mur_k_ff[25]}}, mur_k_ff};
               mul_b = diff33(e_cur_ff.y, bf_sel[0]);
            end
            if (sub_ff == 4'd3) begin
               mul_a = {{7{mur_k_ff[25]}}, mur_k_ff};
               mul_b = diff33(e_cur_ff.z, bf_sel[1]);
            end
            if (sub_ff == 4'd4) begin
               e_we    = 1'b1;
               e_wdata = {e_nxt_ff.x, sat_y.val, sat_z.val};
               wr_clip = sat_y.clip | sat_z.clip;
            end
         end
         ST_GUARD: begin
            e_raddr = (sub_ff == 4'd0) ? nx_ff : SLOT_W'(1);
            b_raddr = (sub_ff == 4'd0) ? nx_ff : SLOT_W'(1);
            e_waddr = (sub_ff == 4'd1) ? '0 : (nx_ff + SLOT_W'(1));
            b_waddr = (sub_ff == 4'd1) ? '0 : (nx_ff + SLOT_W'(1));
            e_wdata = e_rd_ff;
            b_wdata = b_rd_ff;
            e_we    = (sub_ff != 4'd0);
            b_we    = (sub_ff != 4'd0);
         end
         ST_WIN: begin
            if (sub_ff == 4'd0) begin
               mul_a = {1'b0, step_ff};
               mul_b = {2'b00, dt_ff};
            end
            if (sub_ff == 4'd1) begin
               mul_a = {2'b00, cs_ff};
               mul_b = {1'b0, wsc_ff};
            end
         end
         ST_SHIFT: begin
            e_raddr = s_ff + SLOT_W'(1);
            b_raddr = s_ff + SLOT_W'(1);
            e_wdata = e_rd_ff;
            b_wdata = b_rd_ff;
            e_we    = (sub_ff == 4'd1);
            b_we    = (sub_ff == 4'd1);
         end
         ST_ZERO: begin
            e_we = 1'b1;
            b_we = 1'b1;
         end
         default: begin
            e_we = 1'b0;
         end
      endcase
   end

   // Field memories
   always_ff @(posedge clock) begin
      if (e_we) e_mem[e_waddr] <= e_wdata;
      if (b_we) b_mem[b_waddr] <= b_wdata;
      if (j_we) j_mem[j_waddr] <= j_wdata;
      e_rd_ff <= e_mem[e_raddr];
      b_rd_ff <= b_mem[b_raddr];
      j_rd_ff <= j_mem[j_raddr];
   end

   // Shared multiplier, registered
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Slot loop end tests
   always_comb begin
      unique case (state_ff)
         ST_HB:    last_slot = (s_ff == nx_ff + SLOT_W'(1));
         ST_E:     last_slot = (s_ff == nx_ff + SLOT_W'(2));
         ST_SHIFT: last_slot = (s_ff == nx_ff - SLOT_W'(1));
         ST_ZERO:  last_slot = (s_ff == nx_ff + SLOT_W'(2));
         ST_CLEAR: last_slot = (s_ff == SLOT_W'(SLOTS - 1));
         default:  last_slot = 1'b0;
      endcase
   end

   // Sequencer and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sub_ff       <= '0;
         s_ff         <= '0;
         nx_ff        <= SLOT_W'(2);
         pass2_ff     <= 1'b0;
         side_ff      <= 1'b0;
         clip_ff      <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dt_ff        <= 31'd16777216;
         cs_ff        <= 31'd16777216;
         hc_ff        <= 31'd8388608;
         cr_ff        <= 31'd16777216;
         mur_k_ff     <= '0;
         bmode_ff     <= 1'b0;
         wen_ff       <= 1'b0;
         cc_ff        <= 11'd1024;
         step_ff      <= '0;
         wsc_ff       <= '0;
         mur_bf_lo_ff <= '0;
         mur_bf_hi_ff <= '0;
         mur_pe_lo_ff <= '0;
         mur_pe_hi_ff <= '0;
      end else begin
         // Configuration writes
         if (csr_valid) begin
            unique case (csr_index)
               REG_TIME_STEP:     dt_ff    <= csr_data[30:0];
               REG_CELL_SIZE:     cs_ff    <= csr_data[30:0];
               REG_HALF_COURANT:  hc_ff    <= csr_data[30:0];
               REG_COURANT:       cr_ff    <= csr_data[30:0];
               REG_MUR_COEFF:     mur_k_ff <= csr_data[25:0];
               REG_BOUNDARY_MODE: bmode_ff <= csr_data[0];
               REG_WINDOW_ENABLE: wen_ff   <= csr_data[0];
               REG_CELL_COUNT:    cc_ff    <= csr_data[10:0];
            endcase
         end

         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         clip_ff <= clip_ff | wr_clip;

         unique case (state_ff)
            ST_CLEAR: begin
               s_ff <= s_ff + SLOT_W'(1);
               if (last_slot) begin
                  s_ff     <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_take) begin
                  res_ff   <= '0;
                  rd_ok_ff <= slot_ok;
                  unique case (req_data.opcode)
                     OP_READ: state_ff <= ST_READ;
                     OP_ADVANCE: begin
                        nx_ff    <= nx_calc[SLOT_W-1:0];
                        clip_ff  <= 1'b0;
                        pass2_ff <= 1'b0;
                        side_ff  <= 1'b0;
                        s_ff     <= '0;
                        sub_ff   <= '0;
                        state_ff <= ST_HB;
                     end
                     default: state_ff <= ST_PUT;
                  endcase
               end
            end
            ST_READ: begin
               if (rd_ok_ff) begin
                  res_ff.e_x <= e_rd_ff.x;
                  res_ff.e_y <= e_rd_ff.y;
                  res_ff.e_z <= e_rd_ff.z;
                  res_ff.b_x <= b_rd_ff.x;
                  res_ff.b_y <= b_rd_ff.y;
                  res_ff.b_z <= b_rd_ff.z;
               end
               state_ff <= ST_PUT;
            end
            ST_PUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_HB: begin
               sub_ff <= sub_ff + 4'd1;
               unique case (sub_ff)
                  4'd1: e_cur_ff <= e_rd_ff;
                  4'd2: begin
                     e_nxt_ff <= e_rd_ff;
                     b_cur_ff <= b_rd_ff;
                  end
                  4'd4: acc_y_ff <= ext32(b_cur_ff.y) + ext_term(term);
                  4'd5: begin
                     sub_ff <= '0;
                     s_ff   <= s_ff + SLOT_W'(1);
                     if (last_slot) begin
                        if (!pass2_ff) begin
                           s_ff     <= SLOT_W'(1);
                           state_ff <= ST_E;
                        end else begin
                           s_ff     <= '0;
                           state_ff <= bmode_ff ? ST_STEP : ST_GUARD;
                        end
                     end
                  end
                  default: sub_ff <= sub_ff + 4'd1;
               endcase
            end
            ST_E: begin
               sub_ff <= sub_ff + 4'd1;
               unique case (sub_ff)
                  4'd1: b_prv_ff <= b_rd_ff;
                  4'd2: begin
                     e_cur_ff <= e_rd_ff;
                     b_cur_ff <= b_rd_ff;
                     j_cur_ff <= j_rd_ff;
                  end
                  4'd4: acc_x_ff <= ext32(e_cur_ff.x) - ext_term(term);
                  4'd5: acc_y_ff <= ext32(e_cur_ff.y) - ext_term(term);
                  4'd6: acc_y_ff <= acc_y_ff - ext_term(term);
                  4'd7: acc_z_ff <= ext32(e_cur_ff.z) + ext_term(term);
                  4'd8: begin
                     sub_ff <= '0;
                     s_ff   <= s_ff + SLOT_W'(1);
                     if (last_slot) begin
                        s_ff <= '0;
                        if (bmode_ff) begin
                           side_ff  <= 1'b0;
                           state_ff <= ST_MUR;
                        end else begin
                           pass2_ff <= 1'b1;
                           state_ff <= ST_HB;
                        end
                     end
                  end
                  default: sub_ff <= sub_ff + 4'd1;
               endcase
            end
            ST_MUR: begin
               sub_ff <= sub_ff + 4'd1;
               unique case (sub_ff)
                  4'd1: e_cur_ff <= e_rd_ff;
                  4'd2: e_nxt_ff <= e_rd_ff;
                  4'd3: acc_y_ff <= ext32(pe_sel[0]) + ext_term(term);
                  4'd4: begin
                     sub_ff <= '0;
                     if (side_ff) begin
                        mur_bf_hi_ff <= {sat_z.val, sat_y.val};
                        mur_pe_hi_ff <= {e_cur_ff.z, e_cur_ff.y};
                        pass2_ff     <= 1'b1;
                        s_ff         <= '0;
                        state_ff     <= ST_HB;
                     end else begin
                        mur_bf_lo_ff <= {sat_z.val, sat_y.val};
                        mur_pe_lo_ff <= {e_cur_ff.z, e_cur_ff.y};
                        side_ff      <= 1'b1;
                     end
                  end
                  default: sub_ff <= sub_ff + 4'd1;
               endcase
            end
            ST_GUARD: begin
               sub_ff <= sub_ff + 4'd1;
               if (sub_ff == 4'd2) begin
                  sub_ff   <= '0;
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               step_ff <= step_ff + 32'd1;
               sub_ff  <= '0;
               if (wen_ff) begin
                  state_ff <= ST_WIN;
               end else begin
                  res_ff.saturated <= clip_ff;
                  state_ff         <= ST_PUT;
               end
            end
            ST_WIN: begin
               sub_ff <= sub_ff + 4'd1;
               if (sub_ff == 4'd1) begin
                  trav_ff <= prod_ff[63:0];
               end
               if (sub_ff == 4'd2) begin
                  sub_ff <= '0;
                  s_ff   <= '0;
                  if ({1'b0, trav_ff} > win_limit) begin
                     state_ff <= ST_SHIFT;
                  end else begin
                     res_ff.saturated <= clip_ff;
                     state_ff         <= ST_PUT;
                  end
               end
            end
            ST_SHIFT: begin
               sub_ff <= sub_ff + 4'd1;
               if (sub_ff == 4'd1) begin
                  sub_ff <= '0;
                  s_ff   <= s_ff + SLOT_W'(1);
                  if (last_slot) begin
                     s_ff     <= nx_ff;
                     state_ff <= ST_ZERO;
                  end
               end
            end
            ST_ZERO: begin
               s_ff <= s_ff + SLOT_W'(1);
               if (last_slot) begin
                  wsc_ff              <= wsc_ff + 32'd1;
                  res_ff.window_moved <= 1'b1;
                  res_ff.saturated    <= clip_ff;
                  state_ff            <= ST_PUT;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Checks
   `YFA_ASSERT_IMPLIES(a_hb_no_e_write, clock, reset, state_ff == ST_HB, !e_we, "E written in B pass")
   `YFA_ASSERT_IMPLIES(a_hb_slot_range, clock, reset, state_ff == ST_HB, s_ff <= nx_ff + SLOT_W'(1), "B pass slot beyond grid")
   `YFA_ASSERT_IMPLIES(a_e_slot_range, clock, reset, state_ff == ST_E, s_ff != '0 && s_ff <= nx_ff + SLOT_W'(2), "E pass slot out of range")
   `YFA_ASSERT_IMPLIES(a_rsp_from_put, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_PUT, "result without output step")

endmodule

`default_nettype wire
